### sv/mpic_pkg.sv
package mpic_pkg;

	localparam int NUM_SOURCES = 24;

	// Item kinds.
	localparam logic [2:0] ACT_RAISE = 3'd0;
	localparam logic [2:0] ACT_LOWER = 3'd1;
	localparam logic [2:0] ACT_EVAL  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	// Register selectors.
	localparam logic [2:0] REG_MASK    = 3'd0;
	localparam logic [2:0] REG_WAKE    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_PENDING = 3'd3;
	localparam logic [2:0] REG_EDGE    = 3'd4;
	localparam logic [2:0] REG_VECTOR  = 3'd5;

	// Access sizes.
	localparam logic [1:0] SIZE_LONG  = 2'd0;
	localparam logic [1:0] SIZE_UPPER = 2'd1;
	localparam logic [1:0] SIZE_LOWER = 2'd2;
	localparam logic [1:0] SIZE_NONE  = 2'd3;

	localparam logic [31:0] MASK_RESET = 32'h00ff_ffff;
	localparam logic [31:0] WAKE_RESET = 32'h00ff_ffff;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  line;
		logic [2:0]  reg_select;
		logic [1:0]  access_size;
		logic [31:0] write_value;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_request;
		logic [2:0]  level;
		logic [7:0]  vector_base;
	} result_t;

	function automatic logic [31:0] merge_half(input logic [31:0] r, input logic [1:0] size,
			input logic [31:0] v);
		logic [31:0] res;
		unique case (size)
			SIZE_LONG:  res = v;
			SIZE_UPPER: res = {v[15:0], r[15:0]};
			SIZE_LOWER: res = {r[31:16], v[15:0]};
			default:    res = r;
		endcase
		return res;
	endfunction

	function automatic logic [31:0] read_half(input logic [31:0] r, input logic [1:0] size);
		logic [31:0] res;
		unique case (size)
			SIZE_LONG:  res = r;
			SIZE_UPPER: res = {16'h0000, r[31:16]};
			SIZE_LOWER: res = {16'h0000, r[15:0]};
			default:    res = 32'h0000_0000;
		endcase
		return res;
	endfunction

	// Fixed priority: IRQ7 first, then SPIS/TMR1/IRQ6, PEN, the level 4 group, IRQ3, IRQ2, IRQ1.
	function automatic logic [2:0] level_of(input logic [23:0] s);
		logic [2:0] lv;
		priority if ((s & 24'h80_0000) != 24'h0) lv = 3'd7;
		else if ((s & 24'h28_0002) != 24'h0) lv = 3'd6;
		else if ((s & 24'h10_0000) != 24'h0) lv = 3'd5;
		else if ((s & 24'h00_fffd) != 24'h0) lv = 3'd4;
		else if ((s & 24'h04_0000) != 24'h0) lv = 3'd3;
		else if ((s & 24'h02_0000) != 24'h0) lv = 3'd2;
		else if ((s & 24'h01_0000) != 24'h0) lv = 3'd1;
		else lv = 3'd0;
		return lv;
	endfunction

endpackage

### sv/mpic_regs.sv
module mpic_regs import mpic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [23:0] raised_q, pending_q, status_q;
	logic [31:0] mask_q, wake_q;
	logic [15:0] edge_q;
	logic [7:0]  vector_q;

	logic [23:0] raised_n, pending_n, status_n;
	logic [31:0] mask_n, wake_n;
	logic [15:0] edge_n;
	logic [7:0]  vector_n;
	logic [31:0] rd;

	always_comb begin
		logic [7:0]  b;
		logic [23:0] clr;
		logic        do_upd;
		logic        line_ok;

		raised_n = raised_q;
		pending_n = pending_q;
		status_n = status_q;
		mask_n = mask_q;
		wake_n = wake_q;
		edge_n = edge_q;
		vector_n = vector_q;
		rd = 32'h0000_0000;
		do_upd = 1'b0;
		b = 8'h00;
		line_ok = (item.line < 5'(NUM_SOURCES));

		// Status clear bits in a common layout: IRQ1,2,3,6 at 0..3, IRQ7 at 7.
		if (item.access_size == SIZE_LONG)
			b = {item.write_value[23], 3'b000, item.write_value[19:16]};
		else
			b = {item.write_value[7], 3'b000, item.write_value[3:0]};
		clr = 24'h0;
		clr[16] = edge_q[15] & b[0];
		clr[17] = edge_q[14] & b[1];
		clr[18] = edge_q[13] & b[2];
		clr[19] = edge_q[12] & b[3];
		clr[23] = b[7];

		unique case (item.action)
			ACT_RAISE: begin
				if (line_ok) raised_n[item.line] = 1'b1;
			end
			ACT_LOWER: begin
				if (line_ok) raised_n[item.line] = 1'b0;
			end
			ACT_EVAL: do_upd = 1'b1;
			ACT_WRITE: begin
				unique case (item.reg_select)
					REG_MASK: begin
						mask_n = merge_half(mask_q, item.access_size, item.write_value);
						do_upd = (item.access_size != SIZE_NONE);
					end
					REG_WAKE: wake_n = merge_half(wake_q, item.access_size, item.write_value);
					REG_STATUS: begin
						if (item.access_size == SIZE_LONG) begin
							pending_n = pending_q & ~clr;
							do_upd = (clr != 24'h0);
						end else if (item.access_size == SIZE_UPPER) begin
							pending_n = pending_q & ~clr;
							do_upd = 1'b1;
						end
					end
					REG_PENDING: begin
						if (item.access_size == SIZE_UPPER) begin
							pending_n = pending_q & ~{item.write_value[7:0], 16'h0000};
							do_upd = 1'b1;
						end
					end
					REG_EDGE: begin
						if (item.access_size == SIZE_UPPER) edge_n = item.write_value[15:0];
					end
					REG_VECTOR: vector_n = item.write_value[7:0];
					default: ;
				endcase
			end
			ACT_READ: begin
				unique case (item.reg_select)
					REG_MASK:   rd = read_half(mask_q, item.access_size);
					REG_WAKE:   rd = read_half(wake_q, item.access_size);
					REG_STATUS: rd = read_half({8'h00, status_q}, item.access_size);
					REG_PENDING: begin
						if (item.access_size == SIZE_LONG || item.access_size == SIZE_UPPER)
							rd = read_half({8'h00, pending_q}, item.access_size);
					end
					REG_EDGE: begin
						if (item.access_size == SIZE_UPPER) rd = {16'h0000, edge_q};
					end
					REG_VECTOR: rd = {24'h00_0000, vector_q};
					default: ;
				endcase
			end
			default: ;
		endcase

		// Latch raised lines into pending, then mask into status.
		if (do_upd) begin
			pending_n = pending_n | raised_q;
			status_n = pending_n & ~mask_n[23:0];
		end
	end

	always_comb begin
		res.read_data = rd;
		res.irq_request = (status_n != 24'h0);
		res.level = level_of(status_n);
		res.vector_base = {vector_n[7:3], 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raised_q <= '0;
			pending_q <= '0;
			status_q <= '0;
			mask_q <= MASK_RESET;
			wake_q <= WAKE_RESET;
			edge_q <= '0;
			vector_q <= '0;
		end else if (fire) begin
			raised_q <= raised_n;
			pending_q <= pending_n;
			status_q <= status_n;
			mask_q <= mask_n;
			wake_q <= wake_n;
			edge_q <= edge_n;
			vector_q <= vector_n;
		end
	end

`ifndef SYNTHESIS
	a_status_unmasked: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q & mask_q[23:0]) == 24'h0)
		else $error("status holds a masked source");

	a_status_in_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q & ~pending_q) == 24'h0)
		else $error("status holds a source that is not pending");

	a_eval_latches: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == ACT_EVAL |=> (pending_q & $past(raised_q)) == $past(raised_q))
		else $error("evaluate did not latch raised lines into pending");
`endif

endmodule

### sv/masked_priority_interrupt_controller_unit.sv
// Masked priority interrupt controller for 24 sources, with bus registers.
// Slave channel s_axis_*: one item per handshake. tuser carries the item kind
// (raise line, lower line, evaluate, register write, register read), the
// register selector and the access size; tdata carries the source line number
// and the 32-bit write data. Master channel m_axis_*: exactly one result item
// per input item, in order, carrying read data, the request flag, the
// fixed-priority level and the vector base, all taken after the item's effect.
// An accepted item is registered in the input stage; when the output register can
// take a result, the item's register update and result are computed by a short
// masking and priority-encode path and captured in the output register.
// Throughput is one item per cycle while the receiver keeps up; the state
// registers update once per item. When the receiver stalls, the output register
// holds its result and the input stage still takes one more item; only when both
// are full does s_axis_tready drop. Asynchronous reset (arst_n low) empties both
// stages and returns mask and wake to 0x00ffffff and all other registers to zero.
module masked_priority_interrupt_controller_unit import mpic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // line[4:0], write_value[36:5], zero fill
	input  logic [7:0]  s_axis_tuser,  // action[2:0], reg_select[5:3], access_size[7:6]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // read_data[31:0], irq_request[32], level[35:33],
	                                   // vector_base[43:36], zero fill
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    fire;

	// The output register can take a new result when empty or being drained.
	assign advance = !out_valid_q || m_axis_tready;
	assign fire = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action <= s_axis_tuser[2:0];
			item_s1.reg_select <= s_axis_tuser[5:3];
			item_s1.access_size <= s_axis_tuser[7:6];
			item_s1.line <= s_axis_tdata[4:0];
			item_s1.write_value <= s_axis_tdata[36:5];
		end
	end

	mpic_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'h0, res_q.vector_base, res_q.level, res_q.irq_request,
		res_q.read_data};

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input side stalled while the pipeline had room");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item did not reach the output register");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

import mpic_pkg::*;

// Shadow copy of the controller's registers. Every accepted item is applied here
// in order, and the result it must produce is queued for the output monitor.
class irq_ctrl_shadow;
	logic [23:0] raised;
	logic [23:0] pending;
	logic [23:0] status;
	logic [31:0] mask;
	logic [31:0] wake;
	logic [15:0] edge_ctl;
	logic [7:0]  vector;

	result_t expected_results[$];

	int unsigned errors;
	int unsigned checked;
	int unsigned requests;
	int unsigned action_count[8];
	logic [7:0]  levels_seen;

	function new();
		raised   = '0;
		pending  = '0;
		status   = '0;
		mask     = MASK_RESET;
		wake     = WAKE_RESET;
		edge_ctl = '0;
		vector   = '0;
		errors   = 0;
		checked  = 0;
		requests = 0;
		levels_seen = '0;
		foreach (action_count[i]) action_count[i] = 0;
	endfunction

	// Sticky pending picks up the raised lines; status is pending with masked bits removed.
	function void refresh();
		pending = pending | raised;
		status  = pending & ~mask[23:0];
	endfunction

	function logic [2:0] prio_level(input logic [23:0] s);
		if (s[23]) return 3'd7;
		if (s[21] | s[19] | s[1]) return 3'd6;
		if (s[20]) return 3'd5;
		if ((|s[15:2]) | s[0]) return 3'd4;
		if (s[18]) return 3'd3;
		if (s[17]) return 3'd2;
		if (s[16]) return 3'd1;
		return 3'd0;
	endfunction

	// Request bits: IRQ1, IRQ2, IRQ3, IRQ6 at 0..3 (gated by edge control), IRQ7 at 7.
	function bit clear_edge_irqs(input logic [7:0] req);
		bit hit;
		hit = 1'b0;
		if (edge_ctl[15] && req[0]) begin
			pending[16] = 1'b0;
			hit = 1'b1;
		end
		if (edge_ctl[14] && req[1]) begin
			pending[17] = 1'b0;
			hit = 1'b1;
		end
		if (edge_ctl[13] && req[2]) begin
			pending[18] = 1'b0;
			hit = 1'b1;
		end
		if (edge_ctl[12] && req[3]) begin
			pending[19] = 1'b0;
			hit = 1'b1;
		end
		if (req[7]) begin
			pending[23] = 1'b0;
			hit = 1'b1;
		end
		return hit;
	endfunction

	function logic [31:0] half_of(input logic [31:0] r, input logic [1:0] size);
		case (size)
			SIZE_LONG:  return r;
			SIZE_UPPER: return {16'h0000, r[31:16]};
			SIZE_LOWER: return {16'h0000, r[15:0]};
			default:    return 32'h0000_0000;
		endcase
	endfunction

	function void write_reg(input item_t it);
		logic [31:0] v;
		v = it.write_value;
		case (it.reg_select)
			REG_MASK: begin
				if (it.access_size != SIZE_NONE) begin
					case (it.access_size)
						SIZE_LONG:  mask = v;
						SIZE_UPPER: mask[31:16] = v[15:0];
						default:    mask[15:0] = v[15:0];
					endcase
					refresh();
				end
			end
			REG_WAKE: begin
				case (it.access_size)
					SIZE_LONG:  wake = v;
					SIZE_UPPER: wake[31:16] = v[15:0];
					SIZE_LOWER: wake[15:0] = v[15:0];
					default: ;
				endcase
			end
			REG_STATUS: begin
				if (it.access_size == SIZE_LONG) begin
					if (clear_edge_irqs({v[23], 3'b000, v[19:16]}))
						refresh();
				end else if (it.access_size == SIZE_UPPER) begin
					void'(clear_edge_irqs({v[7], 3'b000, v[3:0]}));
					refresh();
				end
			end
			REG_PENDING: begin
				if (it.access_size == SIZE_UPPER) begin
					pending[23:16] = pending[23:16] & ~v[7:0];
					refresh();
				end
			end
			REG_EDGE: begin
				if (it.access_size == SIZE_UPPER)
					edge_ctl = v[15:0];
			end
			REG_VECTOR: vector = v[7:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] read_reg(input item_t it);
		case (it.reg_select)
			REG_MASK:    return half_of(mask, it.access_size);
			REG_WAKE:    return half_of(wake, it.access_size);
			REG_STATUS:  return half_of({8'h00, status}, it.access_size);
			REG_PENDING: begin
				if (it.access_size == SIZE_LONG || it.access_size == SIZE_UPPER)
					return half_of({8'h00, pending}, it.access_size);
				return 32'h0000_0000;
			end
			REG_EDGE:    return (it.access_size == SIZE_UPPER) ? {16'h0000, edge_ctl} : 32'h0;
			REG_VECTOR:  return {24'h000000, vector};
			default:     return 32'h0000_0000;
		endcase
	endfunction

	function void apply_item(input item_t it);
		result_t want;
		want.read_data = 32'h0000_0000;
		action_count[it.action]++;
		case (it.action)
			ACT_RAISE: if (it.line < NUM_SOURCES) raised[it.line] = 1'b1;
			ACT_LOWER: if (it.line < NUM_SOURCES) raised[it.line] = 1'b0;
			ACT_EVAL:  refresh();
			ACT_WRITE: write_reg(it);
			ACT_READ:  want.read_data = read_reg(it);
			default: ;
		endcase
		want.irq_request = |status;
		want.level       = prio_level(status);
		want.vector_base = {vector[7:3], 3'b000};
		expected_results.push_back(want);
	endfunction

	task report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch in %s at result %0d: got %h, expected %h", what, checked, got, want);
		errors++;
	endtask

	task check_result(input logic [47:0] word);
		result_t got;
		result_t want;
		got.read_data   = word[31:0];
		got.irq_request = word[32];
		got.level       = word[35:33];
		got.vector_base = word[43:36];
		if (expected_results.size() == 0) begin
			report("result with nothing outstanding, read_data", got.read_data, 32'h0);
		end else begin
			want = expected_results.pop_front();
			if (got.read_data !== want.read_data)
				report("read_data", got.read_data, want.read_data);
			if (got.irq_request !== want.irq_request)
				report("irq_request", {31'h0, got.irq_request}, {31'h0, want.irq_request});
			if (got.level !== want.level)
				report("level", {29'h0, got.level}, {29'h0, want.level});
			if (got.vector_base !== want.vector_base)
				report("vector_base", {24'h0, got.vector_base}, {24'h0, want.vector_base});
			levels_seen[want.level] = 1'b1;
			if (want.irq_request) requests++;
		end
		checked++;
	endtask
endclass

module tb_top;

	localparam int RANDOM_ITEMS = 500;
	// Worst case is roughly 525 items, each waiting out a long sender gap, a long
	// receiver stall and the two-stage pipeline, well within CYCLE_LIMIT.
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // line[4:0], write_value[36:5], zero fill
	logic [7:0]  s_axis_tuser = '0;  // action[2:0], reg_select[5:3], access_size[7:6]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // read_data[31:0], irq_request[32], level[35:33],
	                                 // vector_base[43:36], zero fill

	// While set, neither side inserts gaps, so items stream back to back.
	bit          no_idle = 1'b0;
	int          ready_hold = 0;
	int unsigned cycles = 0;

	irq_ctrl_shadow shadow = new();

	masked_priority_interrupt_controller_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Gap lengths: mostly none, otherwise short, occasionally a long one.
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Receiver side: alternates runs of readiness with stalls of random length.
	always @(negedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 1) == 1) begin
			m_axis_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 7);
		end else begin
			m_axis_tready <= 1'b0;
			ready_hold <= idle_cycles();
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			shadow.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one item from the falling edge and holds it until the handshake.
	// The valid stays high if the caller sends the next item right away.
	task automatic send_item(input item_t it);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, it.write_value, it.line};
		s_axis_tuser  <= {it.access_size, it.reg_select, it.action};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		shadow.apply_item(it);
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// The sender must already have dropped its valid before calling this.
	task automatic wait_drained();
		while (shadow.expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic drive(input logic [2:0] act, input logic [4:0] ln, input logic [2:0] sel,
			input logic [1:0] size, input logic [31:0] val);
		item_t it;
		it.action      = act;
		it.line        = ln;
		it.reg_select  = sel;
		it.access_size = size;
		it.write_value = val;
		send_item(it);
		idle(idle_cycles());
	endtask

	// Random traffic: mostly line activity and register accesses on valid
	// selectors, with a little noise (out-of-range lines, unknown selectors,
	// access size three, unused actions).
	function automatic item_t random_item();
		item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)      it.action = ACT_RAISE;
		else if (pick < 40) it.action = ACT_LOWER;
		else if (pick < 55) it.action = ACT_EVAL;
		else if (pick < 80) it.action = ACT_WRITE;
		else if (pick < 98) it.action = ACT_READ;
		else                it.action = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 9) == 0) it.line = 5'($urandom_range(24, 31));
		else                           it.line = 5'($urandom_range(0, 23));
		if ($urandom_range(0, 19) == 0) it.reg_select = 3'($urandom_range(6, 7));
		else                            it.reg_select = 3'($urandom_range(0, 5));
		if ($urandom_range(0, 9) == 0) it.access_size = SIZE_NONE;
		else                           it.access_size = 2'($urandom_range(0, 2));
		it.write_value = $urandom;
		// Half of the mask writes open just one or two sources, so every
		// priority level gets a chance to win rather than IRQ7 most of the time.
		if (it.action == ACT_WRITE && it.reg_select == REG_MASK && $urandom_range(0, 1) == 1) begin
			it.write_value = ~((32'd1 << $urandom_range(0, 23)) | (32'd1 << $urandom_range(0, 23)));
			if (it.access_size == SIZE_UPPER)
				it.write_value = it.write_value >> 16;
		end
		return it;
	endfunction

	initial begin
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers.
		drive(ACT_READ, 5'd0, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_READ, 5'd0, REG_WAKE, SIZE_UPPER, 32'h0);
		// Extreme source lines; lines past the last source must be ignored.
		drive(ACT_RAISE, 5'd0, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_RAISE, 5'd23, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_RAISE, 5'd24, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_RAISE, 5'd31, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_LOWER, 5'd31, REG_MASK, SIZE_LONG, 32'h0);
		// Pending picks up lines 0 and 23 but everything is still masked.
		drive(ACT_EVAL, 5'd0, REG_MASK, SIZE_LONG, 32'h0);
		// Unmask the low half (level 4), then IRQ7 through the upper half (level 7).
		drive(ACT_WRITE, 5'd0, REG_MASK, SIZE_LOWER, 32'hFFFF_0000);
		drive(ACT_WRITE, 5'd0, REG_MASK, SIZE_UPPER, 32'h0000_007F);
		drive(ACT_READ, 5'd0, REG_STATUS, SIZE_LONG, 32'h0);
		// Arm all edge controls, drop IRQ7's line and clear it through status.
		drive(ACT_WRITE, 5'd0, REG_EDGE, SIZE_UPPER, 32'hFFFF_F000);
		drive(ACT_LOWER, 5'd23, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_WRITE, 5'd0, REG_STATUS, SIZE_LONG, 32'hFFFF_FFFF);
		drive(ACT_WRITE, 5'd0, REG_STATUS, SIZE_LOWER, 32'hFFFF_FFFF);
		drive(ACT_WRITE, 5'd0, REG_STATUS, SIZE_UPPER, 32'h0000_008F);
		// Pending: only the upper word write clears; the long write is dropped.
		drive(ACT_WRITE, 5'd0, REG_PENDING, SIZE_LONG, 32'hFFFF_FFFF);
		drive(ACT_READ, 5'd0, REG_PENDING, SIZE_LONG, 32'h0);
		drive(ACT_WRITE, 5'd0, REG_PENDING, SIZE_UPPER, 32'h0000_00FF);
		drive(ACT_READ, 5'd0, REG_PENDING, SIZE_LOWER, 32'h0);
		// RTI on its own raises the request but has no level.
		drive(ACT_RAISE, 5'd22, REG_MASK, SIZE_LONG, 32'h0);
		drive(ACT_WRITE, 5'd0, REG_MASK, SIZE_LONG, 32'hFFBF_FFFF);
		// Vector takes the low byte whatever the access size.
		drive(ACT_WRITE, 5'd0, REG_VECTOR, SIZE_NONE, 32'hFFFF_FFFF);
		drive(ACT_READ, 5'd0, REG_VECTOR, SIZE_NONE, 32'h0);
		// Unsupported accesses and an unused action leave everything alone, then wake is cleared.
		drive(ACT_WRITE, 5'd0, 3'd7, SIZE_LONG, 32'hFFFF_FFFF);
		drive(ACT_READ, 5'd0, REG_EDGE, SIZE_LOWER, 32'h0);
		drive(3'd7, 5'd0, REG_WAKE, SIZE_LONG, 32'h0);
		drive(ACT_WRITE, 5'd0, REG_WAKE, SIZE_LONG, 32'h0000_0000);

		// Let the pipeline empty completely before the random part.
		idle(1);
		wait_drained();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				idle(1);
				wait_drained();
			end
			no_idle = (n % 125) < 20;
			send_item(random_item());
			if (!no_idle) idle(idle_cycles());
		end

		idle(1);
		no_idle = 1'b0;
		wait_drained();
		// Waiting on afterwards catches any result the block emits beyond the last one due.
		repeat (20) @(posedge clk);

		$display("Drove %0d items: raise %0d, lower %0d, evaluate %0d, write %0d, read %0d.",
			shadow.action_count[ACT_RAISE] + shadow.action_count[ACT_LOWER]
			+ shadow.action_count[ACT_EVAL] + shadow.action_count[ACT_WRITE]
			+ shadow.action_count[ACT_READ] + shadow.action_count[5]
			+ shadow.action_count[6] + shadow.action_count[7],
			shadow.action_count[ACT_RAISE], shadow.action_count[ACT_LOWER],
			shadow.action_count[ACT_EVAL], shadow.action_count[ACT_WRITE],
			shadow.action_count[ACT_READ]);
		$display("Checked %0d results, %0d with a request raised; levels reached %b.",
			shadow.checked, shadow.requests, shadow.levels_seen);
		if (shadow.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
